// ===== src/sdcs_pkg.sv =====
`default_nettype none
package sdcs_pkg;

   localparam logic [1:0] RETRY_LIMIT_DEF = 2'd3;

   localparam logic [2:0] CMD_INIT    = 3'd0;
   localparam logic [2:0] CMD_RESP    = 3'd1;
   localparam logic [2:0] CMD_TIMEOUT = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_WRITE   = 3'd4;
   localparam logic [2:0] CMD_DDONE   = 3'd5;

   localparam logic [2:0] KIND_ISSUE     = 3'd0;
   localparam logic [2:0] KIND_INIT_DONE = 3'd1;
   localparam logic [2:0] KIND_INIT_FAIL = 3'd2;
   localparam logic [2:0] KIND_DATA      = 3'd3;
   localparam logic [2:0] KIND_OP_DONE   = 3'd4;
   localparam logic [2:0] KIND_OP_FAIL   = 3'd5;

   localparam logic [2:0] RK_NONE = 3'd0;
   localparam logic [2:0] RK_R1   = 3'd1;
   localparam logic [2:0] RK_R1B  = 3'd2;
   localparam logic [2:0] RK_R3   = 3'd4;
   localparam logic [2:0] RK_R7   = 3'd5;
   localparam logic [2:0] RK_LONG = 3'd6;

   localparam logic [31:0] ARG_IFC      = 32'h0000_01AA;
   localparam logic [31:0] ARG_OCR_SD   = 32'h40FF_8000;
   localparam logic [31:0] ARG_OCR_SPI  = 32'h4000_0000;
   localparam logic [31:0] RESP_DATA_OK = 32'h0000_0900;
   localparam logic [31:0] ARG_BUS4     = 32'h0000_0002;
   localparam logic [31:0] ARG_BLEN     = 32'd512;
   localparam logic [3:0]  ST_DATA      = 4'hF & 4'd5;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  opcode;
      logic [31:0] argument;
      logic [2:0]  resp_kind;
      logic        check_crc;
      logic        carries_data;
      logic        is_read;
      logic [15:0] xfer_blocks;
      logic [15:0] block_bytes;
      logic [31:0] total_blocks;
      logic        high_capacity;
      logic [16:0] op_result;
   } rsp_type;

   function automatic rsp_type f_issue(input logic [5:0] op, input logic [31:0] arg,
                                       input logic [2:0] rk, input logic crc);
      rsp_type r;
      r = '0;
      r.kind = KIND_ISSUE;
      r.opcode = op;
      r.argument = arg;
      r.resp_kind = rk;
      r.check_crc = crc;
      return r;
   endfunction

   function automatic rsp_type f_signal(input logic [2:0] k);
      rsp_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/sdcs_csd_decode.sv =====
`default_nettype none
module sdcs_csd_decode (
   input  wire logic [63:0] resp_hi,
   input  wire logic [63:0] resp_lo,
   output logic      [15:0] size_bytes,
   output logic      [31:0] size_blocks
);
   logic [1:0]  ver;
   logic [32:0] blocks;

   assign ver = resp_hi[55:54];

   always_comb begin
      size_bytes = 16'd512;
      blocks = '0;
      case (ver)
         2'd0: begin
            size_bytes = 16'd1 << resp_hi[11:8];
            blocks = {20'd0, {1'b0, resp_hi[1:0], resp_lo[63:54]} + 13'd1}
                     << ({1'b0, resp_lo[41:39]} + 4'd2);
         end
         2'd1: begin
            size_bytes = 16'd1 << resp_hi[11:8];
            blocks = {({1'b0, resp_lo[61:40]} + 23'd1), 10'd0};
         end
         default: begin
            size_bytes = 16'd512;
            blocks = '0;
         end
      endcase
      size_blocks = blocks[32] ? 32'hFFFF_FFFF : blocks[31:0];
   end
endmodule
`default_nettype wire

// ===== src/sdcs_core.sv =====
`default_nettype none
module sdcs_core #(
   parameter logic [1:0] RETRY_LIMIT = sdcs_pkg::RETRY_LIMIT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        spi_mode,
   input  wire logic [2:0]  cmd,
   input  wire logic [63:0] resp_hi,
   input  wire logic [63:0] resp_lo,
   input  wire logic [31:0] block_addr,
   input  wire logic [15:0] block_count,
   input  wire logic [16:0] moved_count,
   output logic             has_result,
   output sdcs_pkg::rsp_type result
);
   import sdcs_pkg::*;

   localparam logic [4:0] P_IDLE = 5'd0, P_GO = 5'd1, P_IFC = 5'd2, P_APP = 5'd3,
      P_OPC = 5'd4, P_OCR = 5'd5, P_CID = 5'd6, P_RCA = 5'd7, P_CSD = 5'd8,
      P_SEL = 5'd9, P_BLEN = 5'd10, P_WAPP = 5'd11, P_WID = 5'd12, P_READY = 5'd13,
      P_STAT = 5'd14, P_STOP = 5'd15, P_STAT2 = 5'd16, P_DCMD = 5'd17,
      P_DATA = 5'd18, P_RSTOP = 5'd19;

   logic [4:0]  phase_ff, phase_in;
   logic [15:0] card_addr_ff, card_addr_in;
   logic        sdhc_ff, sdhc_in;
   logic [1:0]  retry_ff, retry_in;
   logic [31:0] req_addr_ff, req_addr_in;
   logic [15:0] req_count_ff, req_count_in;
   logic        req_rd_ff, req_rd_in;
   logic [15:0] size_bytes_ff, size_bytes_in;
   logic [31:0] size_blocks_ff, size_blocks_in;
   logic [16:0] moved_ff, moved_in;
   logic [15:0] csd_bytes;
   logic [31:0] csd_blocks;
   logic [31:0] r;

   sdcs_csd_decode u_csd (
      .resp_hi(resp_hi), .resp_lo(resp_lo),
      .size_bytes(csd_bytes), .size_blocks(csd_blocks)
   );

   assign r = resp_lo[31:0];

   function automatic rsp_type data_cmd(input logic [31:0] addr, input logic [15:0] cnt,
                                        input logic rd, input logic hc, input logic spi);
      rsp_type x;
      logic [5:0] op;
      op = rd ? ((spi && cnt == 16'd1) ? 6'd17 : 6'd18) : 6'd25;
      x = f_issue(op, hc ? addr : {addr[22:0], 9'd0}, RK_R1, 1'b0);
      x.carries_data = 1'b1;
      x.is_read = rd;
      x.xfer_blocks = cnt;
      return x;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      card_addr_in = card_addr_ff;
      sdhc_in = sdhc_ff;
      retry_in = retry_ff;
      req_addr_in = req_addr_ff;
      req_count_in = req_count_ff;
      req_rd_in = req_rd_ff;
      size_bytes_in = size_bytes_ff;
      size_blocks_in = size_blocks_ff;
      moved_in = moved_ff;
      has_result = 1'b0;
      result = '0;
      case (cmd)
         CMD_INIT: begin
            phase_in = P_GO;
            has_result = 1'b1;
            result = f_issue(6'd0, 32'd0, RK_NONE, 1'b0);
         end
         CMD_RESP: begin
            has_result = 1'b1;
            case (phase_ff)
               P_GO: begin
                  phase_in = P_IFC;
                  result = f_issue(6'd8, ARG_IFC, RK_R7, 1'b1);
               end
               P_IFC: begin
                  phase_in = P_APP;
                  result = f_issue(6'd55, 32'd0, RK_R1, 1'b1);
               end
               P_OPC: begin
                  if (spi_mode ? (r == 32'd0) : r[31]) begin
                     sdhc_in = r[30];
                     if (spi_mode) begin
                        phase_in = P_OCR;
                        result = f_issue(6'd58, 32'd0, RK_R3, 1'b0);
                     end else begin
                        phase_in = P_CID;
                        result = f_issue(6'd2, {card_addr_ff, 16'd0}, RK_LONG, 1'b1);
                     end
                  end else begin
                     phase_in = P_APP;
                     result = f_issue(6'd55, 32'd0, RK_R1, 1'b1);
                  end
               end
               P_APP: begin
                  phase_in = P_OPC;
                  result = f_issue(6'd41, spi_mode ? ARG_OCR_SPI : ARG_OCR_SD,
                                   spi_mode ? RK_R1 : RK_R3, 1'b0);
               end
               P_OCR: begin
                  sdhc_in = r[30];
                  phase_in = P_CID;
                  result = f_issue(6'd10, {card_addr_ff, 16'd0}, RK_LONG, 1'b1);
               end
               P_CID: begin
                  if (!spi_mode) begin
                     phase_in = P_RCA;
                     result = f_issue(6'd3, 32'd0, RK_R7, 1'b1);
                  end else begin
                     phase_in = P_CSD;
                     result = f_issue(6'd9, {card_addr_ff, 16'd0}, RK_LONG, 1'b1);
                  end
               end
               P_RCA: begin
                  card_addr_in = r[31:16];
                  phase_in = P_CSD;
                  result = f_issue(6'd9, {r[31:16], 16'd0}, RK_LONG, 1'b1);
               end
               P_CSD, P_SEL: begin
                  if (phase_ff == P_CSD) begin
                     size_bytes_in = csd_bytes;
                     size_blocks_in = csd_blocks;
                  end
                  if (phase_ff == P_CSD && !spi_mode) begin
                     phase_in = P_SEL;
                     result = f_issue(6'd7, {card_addr_ff, 16'd0}, RK_R1B, 1'b1);
                  end else if (!sdhc_ff) begin
                     phase_in = P_BLEN;
                     result = f_issue(6'd16, ARG_BLEN, RK_R1, 1'b1);
                  end else if (spi_mode) begin
                     phase_in = P_READY;
                     result = f_signal(KIND_INIT_DONE);
                     result.block_bytes = size_bytes_in;
                     result.total_blocks = size_blocks_in;
                     result.high_capacity = sdhc_ff;
                  end else begin
                     phase_in = P_WAPP;
                     result = f_issue(6'd55, {card_addr_ff, 16'd0}, RK_R1, 1'b1);
                  end
               end
               P_BLEN, P_WID: begin
                  if (phase_ff == P_BLEN && !spi_mode) begin
                     phase_in = P_WAPP;
                     result = f_issue(6'd55, {card_addr_ff, 16'd0}, RK_R1, 1'b1);
                  end else begin
                     phase_in = P_READY;
                     result = f_signal(KIND_INIT_DONE);
                     result.block_bytes = size_bytes_ff;
                     result.total_blocks = size_blocks_ff;
                     result.high_capacity = sdhc_ff;
                  end
               end
               P_WAPP: begin
                  phase_in = P_WID;
                  result = f_issue(6'd6, ARG_BUS4, RK_R1, 1'b1);
               end
               P_STAT: begin
                  if (r[12:9] == ST_DATA) begin
                     phase_in = P_STOP;
                     result = f_issue(6'd12, 32'd0, RK_R1B, 1'b1);
                  end else begin
                     phase_in = P_DCMD;
                     result = data_cmd(req_addr_ff, req_count_ff, req_rd_ff, sdhc_ff, spi_mode);
                  end
               end
               P_STOP: begin
                  phase_in = P_STAT2;
                  result = f_issue(6'd13, {card_addr_ff, 16'd0}, RK_R1, 1'b1);
               end
               P_STAT2: begin
                  phase_in = P_DCMD;
                  result = data_cmd(req_addr_ff, req_count_ff, req_rd_ff, sdhc_ff, spi_mode);
               end
               P_DCMD: begin
                  if ((spi_mode && !r[0]) || r == RESP_DATA_OK) begin
                     phase_in = P_DATA;
                     result = f_signal(KIND_DATA);
                     result.carries_data = 1'b1;
                     result.is_read = req_rd_ff;
                     result.xfer_blocks = req_count_ff;
                  end else begin
                     phase_in = P_READY;
                     result = f_signal(KIND_OP_FAIL);
                  end
               end
               default: has_result = 1'b0;
            endcase
         end
         CMD_TIMEOUT: begin
            has_result = 1'b1;
            if (phase_ff >= P_GO && phase_ff <= P_WID) begin
               phase_in = P_IDLE;
               result = f_signal(KIND_INIT_FAIL);
            end else begin
               case (phase_ff)
                  P_STAT: begin
                     if (!req_rd_ff || retry_ff >= RETRY_LIMIT) begin
                        phase_in = P_READY;
                        result = f_signal(KIND_OP_FAIL);
                     end else begin
                        phase_in = P_DCMD;
                        result = data_cmd(req_addr_ff, req_count_ff, req_rd_ff, sdhc_ff,
                                          spi_mode);
                     end
                  end
                  P_STOP, P_STAT2, P_DCMD: begin
                     phase_in = P_READY;
                     result = f_signal(KIND_OP_FAIL);
                  end
                  default: has_result = 1'b0;
               endcase
            end
         end
         CMD_READ, CMD_WRITE: begin
            has_result = 1'b1;
            if (phase_ff != P_READY || (!spi_mode && card_addr_ff == 16'd0)) begin
               result = f_signal(KIND_OP_FAIL);
            end else begin
               req_addr_in = block_addr;
               req_count_in = block_count;
               req_rd_in = (cmd == CMD_READ);
               retry_in = 2'd0;
               if (spi_mode) begin
                  phase_in = P_DCMD;
                  result = data_cmd(block_addr, block_count, req_rd_in, sdhc_ff, spi_mode);
               end else begin
                  phase_in = P_STAT;
                  result = f_issue(6'd13, {card_addr_ff, 16'd0}, RK_R1, 1'b1);
               end
            end
         end
         default: has_result = 1'b0;
      endcase

      if ((cmd == CMD_DDONE && phase_ff == P_DATA) ||
          (cmd == CMD_RESP && phase_ff == P_RSTOP) ||
          (cmd == CMD_TIMEOUT && phase_ff == P_RSTOP)) begin
         has_result = 1'b1;
         if (cmd == CMD_DDONE) moved_in = moved_count;
         if (cmd == CMD_DDONE && req_rd_ff && spi_mode && req_count_ff != 16'd1) begin
            phase_in = P_RSTOP;
            result = f_issue(6'd12, 32'd0, RK_R1B, 1'b0);
         end else if (cmd == CMD_TIMEOUT && retry_ff >= RETRY_LIMIT) begin
            phase_in = P_READY;
            result = f_signal(KIND_OP_FAIL);
         end else if (!req_rd_ff || moved_in[16] || moved_in == {1'b0, req_count_ff}) begin
            phase_in = P_READY;
            result = f_signal(KIND_OP_DONE);
            result.op_result = moved_in;
         end else if (retry_ff >= RETRY_LIMIT) begin
            phase_in = P_READY;
            result = f_signal(KIND_OP_FAIL);
         end else begin
            retry_in = retry_ff + 2'd1;
            if (spi_mode) begin
               phase_in = P_DCMD;
               result = data_cmd(req_addr_ff, req_count_ff, req_rd_ff, sdhc_ff, spi_mode);
            end else begin
               phase_in = P_STAT;
               result = f_issue(6'd13, {card_addr_ff, 16'd0}, RK_R1, 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         card_addr_ff <= '0;
         sdhc_ff <= 1'b0;
         retry_ff <= '0;
         req_addr_ff <= '0;
         req_count_ff <= '0;
         req_rd_ff <= 1'b0;
         size_bytes_ff <= 16'd512;
         size_blocks_ff <= '0;
         moved_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         card_addr_ff <= card_addr_in;
         sdhc_ff <= sdhc_in;
         retry_ff <= retry_in;
         req_addr_ff <= req_addr_in;
         req_count_ff <= req_count_in;
         req_rd_ff <= req_rd_in;
         size_bytes_ff <= size_bytes_in;
         size_blocks_ff <= size_blocks_in;
         moved_ff <= moved_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/sd_card_command_sequencer.sv =====
`default_nettype none
// Channel  Direction  tuser        tdata
// req      in         cmd          resp_hi, resp_lo, block_addr, block_count, moved_count
// rsp      out        kind         opcode .. op_result
// csr      in         -            spi_mode
// An accepted event is registered, decided from the input register and its result
// registered in the output register; one event is taken every cycle unless rsp stalls.
// Reset is synchronous and returns the sequencer to idle with spi_mode cleared.
// A result waiting on rsp_tready holds the decision stage; an empty input register
// still takes one event while the stall lasts.
module sd_card_command_sequencer #(
   parameter logic [1:0] RETRY_LIMIT = sdcs_pkg::RETRY_LIMIT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_data,     // spi_mode
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [2:0]   req_tuser,    // cmd
   input  wire logic [199:0] req_tdata,    // resp_hi, resp_lo, block_addr, block_count,
                                           // moved_count
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [2:0]        rsp_tuser,    // kind
   output logic [127:0]      rsp_tdata     // opcode, argument, resp_kind, check_crc,
                                           // carries_data, is_read, xfer_blocks,
                                           // block_bytes, total_blocks, high_capacity,
                                           // op_result
);
   import sdcs_pkg::*;

   logic         spi_ff;
   logic         in_valid_ff;
   logic [2:0]   in_cmd_ff;
   logic [192:0] in_data_ff;
   logic         out_valid_ff;
   rsp_type      out_ff;
   logic         step;
   logic         has_result;
   rsp_type      result;

   assign csr_ready = 1'b1;
   assign step = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   sdcs_core #(.RETRY_LIMIT(RETRY_LIMIT)) u_core (
      .clock(clock), .reset(reset), .step(step), .spi_mode(spi_ff),
      .cmd(in_cmd_ff),
      .resp_hi(in_data_ff[63:0]), .resp_lo(in_data_ff[127:64]),
      .block_addr(in_data_ff[159:128]), .block_count(in_data_ff[175:160]),
      .moved_count(in_data_ff[192:176]),
      .has_result(has_result), .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         spi_ff <= 1'b0;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) spi_ff <= csr_data[0];
         if (req_tready) in_valid_ff <= req_tvalid;
         if (step) out_valid_ff <= has_result;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_data_ff <= req_tdata[192:0];
      end
      if (step) out_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_ff.kind;
   assign rsp_tdata = {2'b00, out_ff.op_result, out_ff.high_capacity, out_ff.total_blocks,
                       out_ff.block_bytes, out_ff.xfer_blocks, out_ff.is_read,
                       out_ff.carries_data, out_ff.check_crc, out_ff.resp_kind,
                       out_ff.argument, out_ff.opcode};
endmodule
`default_nettype wire
